// ----- sv/hashed_slot_select_top_assert.svh -----
// Assertion macros for the hashed slot select block.
// Clock is clock, reset is reset (synchronous, active high).
`ifndef HASHED_SLOT_SELECT_TOP_ASSERT_SVH
`define HASHED_SLOT_SELECT_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define HSS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define HSS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`else
`define HSS_ASSERT(lbl, prop, msg)
`define HSS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- sv/hss_pkg.sv -----
// ----------------------------------------------------------------------------
// hss_pkg
// Types, constants and SHA-256 helpers for the hashed slot select block.
// ----------------------------------------------------------------------------
package hss_pkg;

   localparam int unsigned MAX_CHAINS = 256;
   localparam int unsigned CNT_W      = 9;
   localparam int unsigned SLOT_W     = 8;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned ROUNDS     = 64;
   localparam int unsigned MOD_STAGES = 8;
   localparam int unsigned MOD_BITS   = 4;

   localparam logic [CSR_IDX_W-1:0] REG_CHAIN_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NONCE_VALUE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DOMAIN_TAG  = 2'd2;

   localparam logic [CNT_W-1:0] CHAIN_COUNT_RST = 9'd1;
   localparam logic [CNT_W-1:0] CHAINS_MAX      = CNT_W'(MAX_CHAINS);

   localparam logic [7:0][31:0] SHA_INIT = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

   localparam logic [31:0] PAD_WORD9_LOW = 32'h0080_0000;
   localparam logic [31:0] LEN_WORD      = 32'h0000_0128;

   typedef struct packed {
      logic [7:0][31:0]  st;
      logic [15:0][31:0] win;
   } hss_rnd_type;

   typedef struct packed {
      logic [31:0]      val;
      logic [CNT_W-1:0] rem;
   } hss_mod_type;

   function automatic logic [31:0] bswap(input logic [31:0] x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      logic [63:0] d;
      d = {x, x} >> n;
      return d[31:0];
   endfunction

   function automatic logic [31:0] sig0(input logic [31:0] x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] sig1(input logic [31:0] x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] big_s0(input logic [31:0] x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_s1(input logic [31:0] x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] sha_k(input logic [5:0] i);
      logic [31:0] k;
      case (i)
         6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

endpackage

// ----- sv/hss_if.sv -----
// ----------------------------------------------------------------------------
// hss_req_if / hss_rsp_if / hss_csr_if
// Valid/ready channels of the hashed slot select block.
// ----------------------------------------------------------------------------
interface hss_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] id_word0;
   logic [63:0] id_word1;
   logic [63:0] id_word2;
   logic [63:0] id_word3;
   modport source (output valid, id_word0, id_word1, id_word2, id_word3, input ready);
   modport sink   (input valid, id_word0, id_word1, id_word2, id_word3, output ready);
endinterface

interface hss_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [hss_pkg::SLOT_W-1:0]      slot;
   modport source (output valid, slot, input ready);
   modport sink   (input valid, slot, output ready);
endinterface

interface hss_csr_if;
   logic                               valid;
   logic                               ready;
   logic [hss_pkg::CSR_IDX_W-1:0]      index;
   logic [hss_pkg::CSR_DATA_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/hss_round.sv -----
// ----------------------------------------------------------------------------
// hss_round
// One registered SHA-256 round with its message schedule step.
// ----------------------------------------------------------------------------
module hss_round (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic [31:0]          k_word,
   input  logic                 vld_in,
   input  hss_pkg::hss_rnd_type d_in,
   output logic                 vld_out,
   output hss_pkg::hss_rnd_type d_out
);

   logic                 vld_ff;
   hss_pkg::hss_rnd_type dat_ff;
   hss_pkg::hss_rnd_type dat_in;
   logic [31:0]          t1;
   logic [31:0]          t2;
   logic [31:0]          ch;
   logic [31:0]          mj;

   always_comb begin
      ch = (d_in.st[4] & d_in.st[5]) ^ (~d_in.st[4] & d_in.st[6]);
      mj = (d_in.st[0] & d_in.st[1]) ^ (d_in.st[0] & d_in.st[2]) ^ (d_in.st[1] & d_in.st[2]);
      t1 = d_in.st[7] + hss_pkg::big_s1(d_in.st[4]) + ch + k_word + d_in.win[0];
      t2 = hss_pkg::big_s0(d_in.st[0]) + mj;
      dat_in.st[0] = t1 + t2;
      dat_in.st[1] = d_in.st[0];
      dat_in.st[2] = d_in.st[1];
      dat_in.st[3] = d_in.st[2];
      dat_in.st[4] = d_in.st[3] + t1;
      dat_in.st[5] = d_in.st[4];
      dat_in.st[6] = d_in.st[5];
      dat_in.st[7] = d_in.st[6];
      for (int j = 0; j < 15; j++) begin
         dat_in.win[j] = d_in.win[j+1];
      end
      dat_in.win[15] = d_in.win[0] + hss_pkg::sig0(d_in.win[1]) + d_in.win[9]
                       + hss_pkg::sig1(d_in.win[14]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dat_ff <= dat_in;
      end
   end

   assign vld_out = vld_ff;
   assign d_out   = dat_ff;

endmodule

// ----- sv/hss_mod_stage.sv -----
// ----------------------------------------------------------------------------
// hss_mod_stage
// Restoring remainder stage: consumes four dividend bits per cycle while adv is high.
// ----------------------------------------------------------------------------
module hss_mod_stage (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic [hss_pkg::CNT_W-1:0]   divisor,
   input  logic                        vld_in,
   input  hss_pkg::hss_mod_type        d_in,
   output logic                        vld_out,
   output hss_pkg::hss_mod_type        d_out
);

   logic                 vld_ff;
   hss_pkg::hss_mod_type dat_ff;
   hss_pkg::hss_mod_type dat_in;
   logic [hss_pkg::CNT_W-1:0] r;

   always_comb begin
      r = d_in.rem;
      for (int b = 0; b < hss_pkg::MOD_BITS; b++) begin
         r = {r[hss_pkg::CNT_W-2:0], d_in.val[31-b]};
         if (r >= divisor) begin
            r = r - divisor;
         end
      end
      dat_in.rem = r;
      dat_in.val = {d_in.val[31-hss_pkg::MOD_BITS:0], {hss_pkg::MOD_BITS{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dat_ff <= dat_in;
      end
   end

   assign vld_out = vld_ff;
   assign d_out   = dat_ff;

endmodule

// ----- sv/hashed_slot_select_top.sv -----
// ----------------------------------------------------------------------------
// hashed_slot_select_top
// Hashes a 32-byte identifier with SHA-256 and picks a slot modulo a count.
//
// Channels: req_ch takes one identifier per transaction (id_word0..3);
// rsp_ch returns one slot per transaction, in order. csr_ch writes the
// chain count (index 0), nonce (index 1) and domain tag (index 2); it is
// always ready. The user must write it only while no transaction is in
// flight; the block does not enforce this. Stages: one input register,
// 64 SHA-256 round stages, one digest stage and eight remainder stages
// of four bits each. Throughput is one transaction per cycle unless stalled.
// The whole pipeline advances together; while rsp_ch is valid and not
// ready, req_ch.ready is low and every stage holds its contents.
// Reset clears all stage valid bits and sets chain count 1, nonce 0, tag 0.
// ----------------------------------------------------------------------------
`include "hashed_slot_select_top_assert.svh"

module hashed_slot_select_top (
   input logic       clock,
   input logic       reset,
   hss_req_if.sink   req_ch,
   hss_rsp_if.source rsp_ch,
   hss_csr_if.sink   csr_ch
);

   logic [hss_pkg::CNT_W-1:0]  chain_count_ff;
   logic [31:0]                nonce_value_ff;
   logic [7:0]                 domain_tag_ff;
   logic [hss_pkg::CNT_W-1:0]  n_eff;
   logic                       adv;

   logic                       rnd_vld [hss_pkg::ROUNDS+1];
   hss_pkg::hss_rnd_type       rnd_dat [hss_pkg::ROUNDS+1];
   hss_pkg::hss_rnd_type       ent_in;
   logic                       ent_vld_ff;
   hss_pkg::hss_rnd_type       ent_ff;

   logic                       dig_vld_ff;
   hss_pkg::hss_mod_type       dig_ff;
   hss_pkg::hss_mod_type       dig_in;

   logic                       mod_vld [hss_pkg::MOD_STAGES+1];
   hss_pkg::hss_mod_type       mod_dat [hss_pkg::MOD_STAGES+1];
   logic [hss_pkg::CNT_W-1:0]  slot_ext;

   // configuration
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_count_ff <= hss_pkg::CHAIN_COUNT_RST;
         nonce_value_ff <= '0;
         domain_tag_ff  <= '0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            hss_pkg::REG_CHAIN_COUNT: chain_count_ff <= csr_ch.data[hss_pkg::CNT_W-1:0];
            hss_pkg::REG_NONCE_VALUE: nonce_value_ff <= csr_ch.data;
            hss_pkg::REG_DOMAIN_TAG:  domain_tag_ff  <= csr_ch.data[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (chain_count_ff == '0) begin
         n_eff = hss_pkg::CNT_W'(1);
      end else if (chain_count_ff > hss_pkg::CHAINS_MAX) begin
         n_eff = hss_pkg::CHAINS_MAX;
      end else begin
         n_eff = chain_count_ff;
      end
   end

   assign adv          = rsp_ch.ready || !rsp_ch.valid;
   assign req_ch.ready = adv;

   // message block assembly
   always_comb begin
      ent_in.st     = hss_pkg::SHA_INIT;
      ent_in.win[0] = hss_pkg::bswap(req_ch.id_word0[31:0]);
      ent_in.win[1] = hss_pkg::bswap(req_ch.id_word0[63:32]);
      ent_in.win[2] = hss_pkg::bswap(req_ch.id_word1[31:0]);
      ent_in.win[3] = hss_pkg::bswap(req_ch.id_word1[63:32]);
      ent_in.win[4] = hss_pkg::bswap(req_ch.id_word2[31:0]);
      ent_in.win[5] = hss_pkg::bswap(req_ch.id_word2[63:32]);
      ent_in.win[6] = hss_pkg::bswap(req_ch.id_word3[31:0]);
      ent_in.win[7] = hss_pkg::bswap(req_ch.id_word3[63:32]);
      ent_in.win[8] = hss_pkg::bswap(nonce_value_ff);
      ent_in.win[9] = {domain_tag_ff, 24'h0} | hss_pkg::PAD_WORD9_LOW;
      for (int j = 10; j < 15; j++) begin
         ent_in.win[j] = '0;
      end
      ent_in.win[15] = hss_pkg::LEN_WORD;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_vld_ff <= 1'b0;
      end else if (adv) begin
         ent_vld_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ent_ff <= ent_in;
      end
   end

   assign rnd_vld[0] = ent_vld_ff;
   assign rnd_dat[0] = ent_ff;

   for (genvar i = 0; i < hss_pkg::ROUNDS; i++) begin : g_round
      hss_round u_round (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .k_word  (hss_pkg::sha_k(6'(i))),
         .vld_in  (rnd_vld[i]),
         .d_in    (rnd_dat[i]),
         .vld_out (rnd_vld[i+1]),
         .d_out   (rnd_dat[i+1])
      );
   end

   // first digest word, little-endian view
   always_comb begin
      dig_in.val = hss_pkg::bswap(hss_pkg::SHA_INIT[0] + rnd_dat[hss_pkg::ROUNDS].st[0]);
      dig_in.rem = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dig_vld_ff <= 1'b0;
      end else if (adv) begin
         dig_vld_ff <= rnd_vld[hss_pkg::ROUNDS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dig_ff <= dig_in;
      end
   end

   assign mod_vld[0] = dig_vld_ff;
   assign mod_dat[0] = dig_ff;

   for (genvar s = 0; s < hss_pkg::MOD_STAGES; s++) begin : g_mod
      hss_mod_stage u_mod (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .divisor (n_eff),
         .vld_in  (mod_vld[s]),
         .d_in    (mod_dat[s]),
         .vld_out (mod_vld[s+1]),
         .d_out   (mod_dat[s+1])
      );
   end

   assign rsp_ch.valid = mod_vld[hss_pkg::MOD_STAGES];
   assign rsp_ch.slot  = mod_dat[hss_pkg::MOD_STAGES].rem[hss_pkg::SLOT_W-1:0];
   assign slot_ext     = mod_dat[hss_pkg::MOD_STAGES].rem;

   `HSS_ASSERT(a_slot_range, !rsp_ch.valid || (slot_ext < n_eff), "slot not below chain count")
   `HSS_ASSERT_NEXT(a_accept_enters, req_ch.valid && req_ch.ready, ent_vld_ff, "accepted transaction lost at entry")
   `HSS_ASSERT_NEXT(a_stall_holds, !adv, $stable(dig_vld_ff) && $stable(mod_vld[4]), "pipeline moved while stalled")
   `HSS_ASSERT(a_ready_when_empty, rsp_ch.valid || req_ch.ready, "input blocked with empty output")

endmodule
